@@ hw/rtl/sstf_pkg.sv @@
// Shared constants, glyph codes and the glyph segment table for the tenths formatter.
package sstf_pkg;

  localparam int ValueW = 20;
  localparam int MagW   = 17;
  localparam int NumW   = 14;

  localparam logic signed [ValueW-1:0] HiLimit   = 20'sd99995;
  localparam logic signed [ValueW-1:0] LoLimit   = -20'sd9995;
  localparam logic signed [ValueW-1:0] WholeHi   = 20'sd1999;
  localparam logic signed [ValueW-1:0] WholeLo   = -20'sd99;

  localparam logic [1:0] MARK_C = 2'd1;
  localparam logic [1:0] MARK_F = 2'd2;

  typedef logic [3:0] glyph_t;

  localparam glyph_t GLYPH_ZERO  = 4'd0;
  localparam glyph_t GLYPH_H     = 4'd10;
  localparam glyph_t GLYPH_I     = 4'd11;
  localparam glyph_t GLYPH_L     = 4'd12;
  localparam glyph_t GLYPH_O     = 4'd13;
  localparam glyph_t GLYPH_BLANK = 4'd14;

  // bit k = segment k+1: top, upper right, lower right, bottom, lower left, upper left, middle
  function automatic logic [6:0] glyph_mask(input glyph_t g);
    logic [6:0] m;
    begin
      case (g)
        4'd0:     m = 7'h3F;
        4'd1:     m = 7'h06;
        4'd2:     m = 7'h5B;
        4'd3:     m = 7'h4F;
        4'd4:     m = 7'h66;
        4'd5:     m = 7'h6D;
        4'd6:     m = 7'h7D;
        4'd7:     m = 7'h07;
        4'd8:     m = 7'h7F;
        4'd9:     m = 7'h6F;
        GLYPH_H:  m = 7'h76;
        GLYPH_I:  m = 7'h10;
        GLYPH_L:  m = 7'h38;
        GLYPH_O:  m = 7'h5C;
        default:  m = 7'h00;
      endcase
      return m;
    end
  endfunction

endpackage

@@ hw/rtl/seven_segment_tenths_formatter.sv @@
// Three-digit seven-segment formatter: signed tenths reading to display buffer segment bytes.
//
// Takes one item per clock while the output is not stalled and shows each result on the
// outputs in the order accepted. Five register stages carry the work: range classify and
// rounding add, divide by ten, digit split by reciprocal multiplies, last
// digit remainders and glyph selection, and segment placement into the output
// register. A stalled output holds each stage that is full while empty stages
// keep filling; a one-item skid buffer at the input keeps in_ready a register.
module seven_segment_tenths_formatter
  import sstf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ValueW-1:0] value,
  input  logic [1:0]               unit_mark,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     leading_one,
  output logic [7:0]               segs_b2,
  output logic [7:0]               segs_b3,
  output logic [7:0]               segs_b4
);

  typedef struct packed {
    logic       hi;
    logic       lo;
    logic       neg;
    logic       point;
    logic [1:0] mark;
  } flags_t;

  // input skid
  logic                     skid_valid;
  logic signed [ValueW-1:0] skid_value;
  logic [1:0]               skid_mark;
  logic                     src_valid;
  logic signed [ValueW-1:0] src_value;
  logic [1:0]               src_mark;

  // stage registers
  logic              v1, v2, v3, v4;
  flags_t            f1, f2, f3, f4;
  logic [MagW-1:0]   m1;
  logic              div1;
  logic [NumW-1:0]   n2;
  logic [3:0]        units3;
  logic [9:0]        q10_3;
  logic [6:0]        q100_3;
  logic              lead3, showh3, showt3;
  logic              lead4;
  glyph_t            gh4, gt4, gu4;

  logic en1, en2, en3, en4, en5;

  // stage 1 combinational
  flags_t                   f1_next;
  logic signed [ValueW-1:0] mag_full;
  logic [MagW-1:0]          mag;
  logic                     whole;

  // stage 2 combinational
  logic [32:0] p10_2;

  // stage 3 combinational
  logic [32:0] p10_3;
  logic [29:0] p100_3;
  logic [9:0]  q10_next;
  logic [6:0]  q100_next;
  logic [NumW-1:0] ten_q10;

  // stage 4 combinational
  logic [17:0] p1000_4;
  logic [3:0]  q1000_next;
  logic [9:0]  ten_q100;
  logic [6:0]  ten_q1000;
  logic [3:0]  tens_next, hund_next;
  logic        special4;

  // stage 5 combinational
  logic [6:0] mh, mt, mu;

  assign en5 = !out_valid || out_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign in_ready  = !skid_valid;
  assign src_valid = skid_valid || in_valid;
  assign src_value = skid_valid ? skid_value : value;
  assign src_mark  = skid_valid ? skid_mark : unit_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid && en1) begin
      skid_valid <= 1'b0;
    end else if (!skid_valid && in_valid && !en1) begin
      skid_valid <= 1'b1;
    end
    if (!skid_valid && in_valid && !en1) begin
      skid_value <= value;
      skid_mark  <= unit_mark;
    end
  end

  // stage 1: classify, magnitude, rounding offset
  always_comb begin
    f1_next.hi    = src_value > HiLimit;
    f1_next.lo    = src_value < LoLimit;
    f1_next.neg   = src_value[ValueW-1];
    whole         = (src_value > WholeHi) || (src_value < WholeLo);
    f1_next.point = !whole;
    f1_next.mark  = src_mark;
    mag_full      = f1_next.neg ? -src_value : src_value;
    mag           = mag_full[MagW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= src_valid;
    end
    if (en1) begin
      f1   <= f1_next;
      div1 <= whole;
      m1   <= whole ? mag + MagW'(5) : mag;
    end
  end

  // stage 2: (m+5)/10 for whole-unit readings
  assign p10_2 = 33'(m1) * 33'd52429;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      f2 <= f1;
      n2 <= div1 ? p10_2[32:19] : m1[NumW-1:0];
    end
  end

  // stage 3: n/10, n/100, units
  always_comb begin
    p10_3     = 33'(n2) * 33'd52429;
    p100_3    = 30'(n2) * 30'd41944;
    q10_next  = p10_3[28:19];
    q100_next = p100_3[28:22];
    ten_q10   = (NumW'(q10_next) << 3) + (NumW'(q10_next) << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      f3     <= f2;
      q10_3  <= q10_next;
      q100_3 <= q100_next;
      units3 <= 4'(n2 - ten_q10);
      lead3  <= n2 > NumW'(999);
      showh3 <= n2 > NumW'(99);
      showt3 <= n2 > NumW'(9);
    end
  end

  // stage 4: tens and hundreds digits, glyph selection
  always_comb begin
    p1000_4    = 18'(q100_3) * 18'd205;
    q1000_next = p1000_4[14:11];
    ten_q100   = (10'(q100_3) << 3) + (10'(q100_3) << 1);
    ten_q1000  = (7'(q1000_next) << 3) + (7'(q1000_next) << 1);
    tens_next  = 4'(q10_3 - ten_q100);
    hund_next  = 4'(q100_3 - ten_q1000);
    special4   = f3.hi || f3.lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (en4) begin
      f4.hi    <= f3.hi;
      f4.lo    <= f3.lo;
      f4.neg   <= f3.neg && !special4;
      f4.point <= f3.point && !special4;
      f4.mark  <= f3.mark;
      lead4    <= lead3 && !special4;
      if (f3.hi) begin
        gh4 <= GLYPH_H;
        gt4 <= GLYPH_I;
        gu4 <= GLYPH_BLANK;
      end else if (f3.lo) begin
        gh4 <= GLYPH_L;
        gt4 <= GLYPH_O;
        gu4 <= GLYPH_BLANK;
      end else begin
        gh4 <= showh3 ? hund_next : GLYPH_BLANK;
        gt4 <= showt3 ? tens_next : GLYPH_ZERO;
        gu4 <= units3;
      end
    end
  end

  // stage 5: segment placement
  assign mh = glyph_mask(gh4);
  assign mt = glyph_mask(gt4);
  assign mu = glyph_mask(gu4);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en5) begin
      out_valid <= v4;
    end
    if (en5) begin
      leading_one <= lead4;
      segs_b2 <= {mt[5], mh[2], mh[1], mh[3], mh[6] | f4.neg, mh[0], mh[4], mh[5]};
      segs_b3 <= {mu[5], f4.point, mt[2], mt[1], mt[3], mt[6], mt[0], mt[4]};
      segs_b4 <= {f4.mark == MARK_F, f4.mark == MARK_C,
                  mu[2], mu[1], mu[3], mu[6], mu[0], mu[4]};
    end
  end

endmodule

@@ hw/rtl/sstf_checker.sv @@
// Port-level checker for the tenths formatter and its bind to the top level.
module sstf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       leading_one,
  input logic [7:0] segs_b2,
  input logic [7:0] segs_b3,
  input logic [7:0] segs_b4
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(leading_one) && $stable(segs_b2)
      && $stable(segs_b3) && $stable(segs_b4))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_marks_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(segs_b4[6] && segs_b4[7]))
    else $error("both unit marks lit");

  // dark units digit means Hi/Lo: no point and no leading one
  a_hilo_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && segs_b4[5:0] == 6'd0 && !segs_b3[7] |-> !segs_b3[6] && !leading_one)
    else $error("Hi/Lo item shows point or leading one");

  // a point reading with the leading one is 100.0 or more, so the hundreds digit shows
  a_point_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && segs_b3[6] && leading_one |-> segs_b2[6:0] != 7'd0)
    else $error("point reading with leading one has a dark hundreds digit");

endmodule

bind seven_segment_tenths_formatter sstf_checker u_sstf_checker (.*);
